[hdl/uvd_pkg.sv]
// Shared constants and types for the UTF-8 validating decoder.
package uvd_pkg;

	localparam int CP_W    = 21;
	localparam int COUNT_W = 3;
	localparam int RUN_W   = 3;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MIN_2BYTE   = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3BYTE   = 21'h000800;
	localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MIN_4BYTE   = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

	localparam logic [1:0] CONT_TAG = 2'b10;

	localparam logic [COUNT_W-1:0] SEQ_NONE = 3'd0;
	localparam logic [COUNT_W-1:0] SEQ_2    = 3'd2;
	localparam logic [COUNT_W-1:0] SEQ_3    = 3'd3;
	localparam logic [COUNT_W-1:0] SEQ_4    = 3'd4;

	// Results caused by one item: a run of replacements, then optionally one scalar.
	typedef struct packed {
		logic [RUN_W-1:0]   repl;
		logic               tail;
		logic [CP_W-1:0]    cp;
		logic [COUNT_W-1:0] bc;
	} uvd_job_t;

endpackage

[hdl/utf8_validating_decoder.sv]
// UTF-8 validating decoder: byte stream in, Unicode scalars with replacement out.
// Bytes enter through a one-item input register; the decode of that byte against the held
// lead and continuation bytes is a single level of logic feeding a result register. An
// item that gives one result, or none, moves on every cycle while the output is not
// stalled, so a stream of well-formed text then runs at one byte per clock. An item that
// gives n results (a broken or invalid sequence, or a flush on the last byte, up to four)
// keeps the result register, one result per accepted output item, and a following item
// that has results of its own waits in the input register until the last of them is
// accepted. Items that only add to a held sequence pass even while results are waiting.
// Each malformed byte yields U+FFFD with the tuser flag set and a byte count of one;
// tlast marks the final result caused by one input item.
module utf8_validating_decoder
	import uvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] byte_count
	output logic [0:0]  m_axis_tuser,   // [0] malformed
	output logic        m_axis_tlast    // last_of_run
);

	// Input register
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;

	// Decoder state
	logic [7:0]         held0_q, held1_q, held2_q;
	logic [1:0]         held_cnt_q;
	logic [COUNT_W-1:0] need_q;

	// Result register
	logic               valid_s2;
	logic [RUN_W-1:0]   repl_s2;
	logic               tail_s2;
	logic [CP_W-1:0]    cp_s2;
	logic [COUNT_W-1:0] bc_s2;

	uvd_job_t           job;
	logic [1:0]         held_cnt_d;
	logic [COUNT_W-1:0] need_d;
	logic               wr0, wr1, wr2;
	logic               cont, seq_open, lead_ok, done_seq;
	logic [COUNT_W-1:0] lead_len;
	logic [CP_W-1:0]    cp2, cp3, cp4, seq_cp;
	logic               seq_ok;
	logic               has_res, adv, out_fire, out_last;

	assign cont     = (byte_s1[7:6] == CONT_TAG);
	assign seq_open = (need_q != SEQ_NONE);
	assign done_seq = ({1'b0, held_cnt_q} + 3'd1) >= need_q;

	always_comb begin
		if (byte_s1[7:5] == 3'b110)
			lead_len = SEQ_2;
		else if (byte_s1[7:4] == 4'b1110)
			lead_len = SEQ_3;
		else if (byte_s1[7:3] == 5'b11110)
			lead_len = SEQ_4;
		else
			lead_len = SEQ_NONE;
	end
	assign lead_ok = (lead_len != SEQ_NONE);

	assign cp2 = {10'd0, held0_q[4:0], byte_s1[5:0]};
	assign cp3 = {5'd0, held0_q[3:0], held1_q[5:0], byte_s1[5:0]};
	assign cp4 = {held0_q[2:0], held1_q[5:0], held2_q[5:0], byte_s1[5:0]};

	always_comb begin
		unique case (need_q)
			SEQ_2: begin
				seq_cp = cp2;
				seq_ok = (cp2 >= CP_MIN_2BYTE);
			end
			SEQ_3: begin
				seq_cp = cp3;
				seq_ok = (cp3 >= CP_MIN_3BYTE) && !((cp3 >= CP_SURR_LO) && (cp3 <= CP_SURR_HI));
			end
			default: begin
				seq_cp = cp4;
				seq_ok = (cp4 >= CP_MIN_4BYTE) && (cp4 <= CP_MAX);
			end
		endcase
	end

	// Work out the results of the byte in the input register and the next decoder state.
	always_comb begin
		job.repl   = '0;
		job.tail   = 1'b0;
		job.cp     = {13'd0, byte_s1};
		job.bc     = 3'd1;
		held_cnt_d = held_cnt_q;
		need_d     = need_q;
		wr0        = 1'b0;
		wr1        = 1'b0;
		wr2        = 1'b0;
		if (seq_open && cont) begin
			if (done_seq) begin
				if (seq_ok) begin
					job.tail = 1'b1;
					job.cp   = seq_cp;
					job.bc   = need_q;
				end else begin
					job.repl = need_q;
				end
				held_cnt_d = 2'd0;
				need_d     = SEQ_NONE;
			end else begin
				wr1        = (held_cnt_q == 2'd1);
				wr2        = (held_cnt_q == 2'd2);
				held_cnt_d = held_cnt_q + 2'd1;
				if (last_s1) begin
					job.repl   = {1'b0, held_cnt_q} + 3'd1;
					held_cnt_d = 2'd0;
					need_d     = SEQ_NONE;
				end
			end
		end else begin
			// A held sequence broken by this byte is flushed first.
			job.repl   = seq_open ? {1'b0, held_cnt_q} : 3'd0;
			held_cnt_d = 2'd0;
			need_d     = SEQ_NONE;
			if (!byte_s1[7]) begin
				job.tail = 1'b1;
			end else if (lead_ok) begin
				wr0 = 1'b1;
				if (last_s1) begin
					job.repl = job.repl + 3'd1;
				end else begin
					held_cnt_d = 2'd1;
					need_d     = lead_len;
				end
			end else begin
				job.repl = job.repl + 3'd1;
			end
		end
	end

	assign has_res  = (job.repl != '0) || job.tail;
	assign out_last = (repl_s2 == '0) || ((repl_s2 == 3'd1) && !tail_s2);
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign adv      = valid_s1 && (!has_res || !valid_s2 || (out_fire && out_last));

	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			need_q     <= SEQ_NONE;
		end else if (adv) begin
			held_cnt_q <= held_cnt_d;
			need_q     <= need_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr0)
			held0_q <= byte_s1;
		if (adv && wr1)
			held1_q <= byte_s1;
		if (adv && wr2)
			held2_q <= byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			repl_s2  <= '0;
			tail_s2  <= 1'b0;
		end else if (adv && has_res) begin
			valid_s2 <= 1'b1;
			repl_s2  <= job.repl;
			tail_s2  <= job.tail;
		end else if (out_fire) begin
			if (out_last)
				valid_s2 <= 1'b0;
			if (repl_s2 != '0)
				repl_s2 <= repl_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			cp_s2 <= job.cp;
			bc_s2 <= job.bc;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tuser[0] = (repl_s2 != '0);
	assign m_axis_tdata    = (repl_s2 != '0) ? {3'd1, CP_REPLACEMENT} : {bc_s2, cp_s2};
	assign m_axis_tlast    = out_last;

	a_held_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q == SEQ_NONE) ? (held_cnt_q == 2'd0)
		                     : ({1'b0, held_cnt_q} < need_q) && (held_cnt_q != 2'd0))
		else $error("held byte count does not fit the open sequence");

	a_need_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q == SEQ_NONE) || (need_q == SEQ_2) || (need_q == SEQ_3) || (need_q == SEQ_4))
		else $error("illegal sequence length held");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((repl_s2 != '0) || tail_s2) && (repl_s2 <= 3'd4))
		else $error("result register holds an empty or oversized run");

	a_no_surrogate: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |->
			!((m_axis_tdata[20:0] >= CP_SURR_LO) && (m_axis_tdata[20:0] <= CP_SURR_HI))
			&& (m_axis_tdata[20:0] <= CP_MAX))
		else $error("well-formed result is not a scalar value");

	a_run_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("result run ended without its last result");

endmodule

[dv/utf8_validating_decoder_checker.sv]
// Scoreboard for the UTF-8 decoder: predicts the scalars for every byte item and checks the outputs.
module utf8_validating_decoder_checker
	import uvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatch_count,
	output int          results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CP_W-1:0]    cp;
		logic               bad;
		logic [COUNT_W-1:0] cnt;
		logic               fin;
	} scalar_t;

	scalar_t        scalar_q[$];
	logic [7:0]     held [3];
	logic [1:0]     held_n;
	logic [2:0]     need;
	int             mismatches = 0;

	assign mismatch_count = mismatches;

	function automatic scalar_t replacement();
		scalar_t r;
		r.cp  = CP_REPLACEMENT;
		r.bad = 1'b1;
		r.cnt = 3'd1;
		r.fin = 1'b0;
		return r;
	endfunction

	// Works out every scalar that one byte item causes and queues them in order.
	task automatic decode_byte(input logic [7:0] b, input logic text_end);
		scalar_t         run[$];
		scalar_t         s;
		logic [CP_W-1:0] cp;
		logic            ok;
		if (need != SEQ_NONE && b[7:6] == CONT_TAG) begin
			if (int'(held_n) + 1 >= int'(need)) begin
				case (need)
					SEQ_2: begin
						cp = {10'd0, held[0][4:0], b[5:0]};
						ok = cp >= CP_MIN_2BYTE;
					end
					SEQ_3: begin
						cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
						ok = cp >= CP_MIN_3BYTE && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
					end
					default: begin
						cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
						ok = cp >= CP_MIN_4BYTE && cp <= CP_MAX;
					end
				endcase
				if (ok) begin
					s.cp  = cp;
					s.bad = 1'b0;
					s.cnt = need;
					s.fin = 1'b0;
					run = {run, s};
				end else begin
					for (int i = 0; i < int'(need); i++) run = {run, replacement()};
				end
				held_n = 2'd0;
				need   = SEQ_NONE;
			end else begin
				held[held_n] = b;
				held_n       = held_n + 2'd1;
			end
		end else begin
			// A sequence broken by this byte gives up its held bytes first.
			for (int i = 0; i < int'(held_n); i++) run = {run, replacement()};
			held_n = 2'd0;
			need   = SEQ_NONE;
			if (!b[7]) begin
				s.cp  = {13'd0, b};
				s.bad = 1'b0;
				s.cnt = 3'd1;
				s.fin = 1'b0;
				run = {run, s};
			end else if (b[7:5] == 3'b110) begin
				held[0] = b;
				held_n  = 2'd1;
				need    = SEQ_2;
			end else if (b[7:4] == 4'b1110) begin
				held[0] = b;
				held_n  = 2'd1;
				need    = SEQ_3;
			end else if (b[7:3] == 5'b11110) begin
				held[0] = b;
				held_n  = 2'd1;
				need    = SEQ_4;
			end else begin
				run = {run, replacement()};
			end
		end
		if (text_end) begin
			for (int i = 0; i < int'(held_n); i++) run = {run, replacement()};
			held_n = 2'd0;
			need   = SEQ_NONE;
		end
		if (run.size() > 0) run[run.size()-1].fin = 1'b1;
		scalar_q = {scalar_q, run};
	endtask

	task automatic check_result();
		scalar_t want;
		if (scalar_q.size() == 0) begin
			$display("%0t: unexpected item: expected none, actual cp %h bad %b cnt %0d last %b",
				$time, m_axis_tdata[20:0], m_axis_tuser[0], m_axis_tdata[23:21], m_axis_tlast);
			mismatches++;
		end else begin
			want = scalar_q.pop_front();
			if (m_axis_tdata[20:0] !== want.cp) begin
				$display("%0t: code_point expected %h actual %h", $time, want.cp,
					m_axis_tdata[20:0]);
				mismatches++;
			end
			if (m_axis_tuser[0] !== want.bad) begin
				$display("%0t: malformed expected %b actual %b", $time, want.bad,
					m_axis_tuser[0]);
				mismatches++;
			end
			if (m_axis_tdata[23:21] !== want.cnt) begin
				$display("%0t: byte_count expected %0d actual %0d", $time, want.cnt,
					m_axis_tdata[23:21]);
				mismatches++;
			end
			if (m_axis_tlast !== want.fin) begin
				$display("%0t: last_of_run expected %b actual %b", $time, want.fin,
					m_axis_tlast);
				mismatches++;
			end
		end
	endtask

	// The input side is handled first so that a result can never overtake its own byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_q.delete();
			held_n      = 2'd0;
			need        = SEQ_NONE;
			results_due = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) check_result();
			results_due = scalar_q.size();
		end
	end

endmodule

[dv/utf8_validating_decoder_tb.sv]
// Top-level testbench for the UTF-8 decoder: byte stimulus, output back-pressure and verdict.
module utf8_validating_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 354;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DIRECTED_N   = 26;

	// Each entry is {last_byte, data_byte}.
	localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
		9'h000, 9'h17F,                 // ASCII extremes, the second ending the text
		9'h080, 9'h0FF,                 // stray continuation and an impossible byte
		9'h0C0, 9'h0AF,                 // overlong two-byte form
		9'h0ED, 9'h0A0, 9'h080,         // surrogate
		9'h0F4, 9'h090, 9'h080, 9'h080, // above the top of the code space
		9'h0EF, 9'h0BF, 9'h0BD,         // properly encoded replacement character
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // highest scalar
		9'h0E2, 9'h082, 9'h041,         // sequence broken by an ASCII byte
		9'h0F1, 9'h080, 9'h180          // end of text flushes three held bytes
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [23:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycles      = 0;
	int bytes_sent  = 0;
	int mismatch_count;
	int results_due;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	utf8_validating_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	utf8_validating_decoder_checker scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[utf8_validating_decoder] ERROR");
			$finish;
		end
	end

	function automatic logic text_ends();
		return $urandom_range(99) < 3;
	endfunction

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic send_byte(input logic [7:0] b, input logic text_end);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= text_end;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Mostly lead-plus-continuation sequences with random payload, some cut short, some noise.
	task automatic send_random(input int count);
		int         stop;
		int         kind;
		int         len;
		int         keep;
		logic [7:0] lead;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				len = $urandom_range(1, 4);
				case (len)
					1: lead = 8'($urandom_range(0, 127));
					2: lead = 8'hC0 | 8'($urandom_range(0, 31));
					3: lead = ($urandom_range(3) == 0) ? 8'hED : 8'hE0 | 8'($urandom_range(0, 15));
					default: lead = ($urandom_range(3) == 0) ? 8'hF4 : 8'hF0 | 8'($urandom_range(0, 7));
				endcase
				keep = (kind < 62) ? len : $urandom_range(1, len);
				send_byte(lead, text_ends());
				for (int i = 1; i < keep; i++)
					send_byte(8'h80 | 8'($urandom_range(0, 63)), text_ends());
			end else begin
				send_byte(8'($urandom_range(0, 255)), text_ends());
			end
		end
	endtask

	// Always leaves at a later falling edge than it was entered at.
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 9;
		rx_idle_pct = 54;
		for (int i = 0; i < DIRECTED_N; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		send_random(RANDOM_ITEMS / 3);
		hold_until_drained();

		tx_idle_pct = 54;
		rx_idle_pct = 9;
		send_random(RANDOM_ITEMS / 3);
		hold_until_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		hold_until_drained();

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("[utf8_validating_decoder] OK");
		end else begin
			$display("[utf8_validating_decoder] ERROR");
		end
		$finish;
	end

endmodule
